// ----- design/ilt_pkg.sv -----
// ----------------------------------------------------------------------------
// ilt_pkg: shared types and constants of the integer list engine
// Field widths, action codes, cell operations and the per-cell control word.
// ----------------------------------------------------------------------------
package ilt_pkg;

   // Default number of list entries.
   localparam int CAPACITY_DEFAULT = 256;

   // Widths of the channel fields.
   localparam int ACTION_W = 3;
   localparam int VALUE_W  = 32;
   localparam int POS_W    = 8;
   localparam int CNT_W    = 9;

   // Actions named by an input word.
   typedef enum logic [ACTION_W-1:0] {
      ACT_PUSH        = 3'd0,
      ACT_PUSH_UNIQUE = 3'd1,
      ACT_FIND        = 3'd2,
      ACT_REMOVE      = 3'd3,
      ACT_SORT        = 3'd4
   } action_type;

   // Operations that every cell of the chain applies in the same cycle.
   typedef enum logic [2:0] {
      OP_HOLD,
      OP_ROTATE,
      OP_DROP,
      OP_SWAP_EVEN,
      OP_SWAP_ODD,
      OP_WRITE
   } cell_op_type;

   // Control word broadcast from the controller to all cells.
   typedef struct packed {
      cell_op_type                op;
      logic signed [VALUE_W-1:0]  wdata;
   } cell_ctrl_type;

endpackage

// ----- design/ilt_req_if.sv -----
// ----------------------------------------------------------------------------
// ilt_req_if: request channel of the integer list engine
// Carries one action word and its value under a valid/ready handshake.
// ----------------------------------------------------------------------------
interface ilt_req_if import ilt_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [ACTION_W-1:0]       action;
   logic signed [VALUE_W-1:0] value;

   modport source (output valid, output action, output value, input ready);
   modport sink   (input valid, input action, input value, output ready);
endinterface

// ----- design/ilt_rsp_if.sv -----
// ----------------------------------------------------------------------------
// ilt_rsp_if: response channel of the integer list engine
// Carries one result word per request under a valid/ready handshake.
// ----------------------------------------------------------------------------
interface ilt_rsp_if import ilt_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             success;
   logic             found;
   logic [POS_W-1:0] position;
   logic [CNT_W-1:0] count_now;
   logic             full_res;

   modport source (output valid, output success, output found, output position,
                   output count_now, output full_res, input ready);
   modport sink   (input valid, input success, input found, input position,
                   input count_now, input full_res, output ready);
endinterface

// ----- design/ilt_cell.sv -----
// ----------------------------------------------------------------------------
// ilt_cell: one list entry of the cell chain
// Holds one value and takes it from a neighbor, the head or the write bus
// as the broadcast operation and its own position in the list decide.
// ----------------------------------------------------------------------------
module ilt_cell import ilt_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input  logic                              clock,
   input  logic [$clog2(CAPACITY)-1:0]       cell_index,
   input  logic [$clog2(CAPACITY+1)-1:0]     count,
   input  cell_ctrl_type                     ctrl,
   input  logic signed [VALUE_W-1:0]         head_value,
   input  logic signed [VALUE_W-1:0]         left_value,
   input  logic signed [VALUE_W-1:0]         right_value,
   output logic signed [VALUE_W-1:0]         stored_value
);

   localparam int CW = $clog2(CAPACITY+1);

   logic signed [VALUE_W-1:0] value_ff;
   logic signed [VALUE_W-1:0] value_in;
   logic [CW-1:0]             idx_ext;
   logic [CW-1:0]             idx_next;
   logic                      live;
   logic                      next_live;
   logic                      is_tail;
   logic                      at_end;
   logic                      phase;

   // Position of this cell relative to the live part of the list.
   assign idx_ext   = CW'(cell_index);
   assign idx_next  = idx_ext + CW'(1);
   assign live      = idx_ext < count;
   assign next_live = idx_next < count;
   assign is_tail   = idx_next == count;
   assign at_end    = idx_ext == count;
   assign phase     = (ctrl.op == OP_SWAP_ODD);

   // Next value of the entry.
   always_comb begin
      value_in = value_ff;
      case (ctrl.op)
         OP_ROTATE: begin
            if (next_live) begin
               value_in = right_value;
            end else if (is_tail) begin
               value_in = head_value;
            end
         end
         OP_DROP: begin
            if (next_live) begin
               value_in = right_value;
            end
         end
         OP_SWAP_EVEN, OP_SWAP_ODD: begin
            if (cell_index[0] == phase) begin
               // Lower cell of a pair keeps the smaller value.
               if (next_live && (value_ff > right_value)) begin
                  value_in = right_value;
               end
            end else if ((cell_index != '0) && live && (left_value > value_ff)) begin
               // Upper cell of a pair keeps the larger value.
               value_in = left_value;
            end
         end
         OP_WRITE: begin
            if (at_end) begin
               value_in = ctrl.wdata;
            end
         end
         default: begin
            value_in = value_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign stored_value = value_ff;

endmodule

// ----- design/ilt_ctrl.sv -----
// ----------------------------------------------------------------------------
// ilt_ctrl: sequencer of the integer list engine
// Accepts request words, steps the cell chain through a scan or a sort,
// keeps the entry count and registers the response word.
// ----------------------------------------------------------------------------
module ilt_ctrl import ilt_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   ilt_req_if.sink                        req_chan,
   ilt_rsp_if.source                      rsp_chan,
   input  logic signed [VALUE_W-1:0]      head_value,
   output cell_ctrl_type                  cell_ctrl,
   output logic [$clog2(CAPACITY+1)-1:0]  count
);

   localparam int IW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY+1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SORT,
      ST_DONE
   } state_type;

   state_type                 state_ff, state_in;
   action_type                action_ff, action_in;
   logic signed [VALUE_W-1:0] key_ff, key_in;
   logic [IW-1:0]             step_ff, step_in;
   logic [CW-1:0]             limit_ff, limit_in;
   logic [CW-1:0]             count_ff, count_in;
   logic                      found_ff, found_in;
   logic [IW-1:0]             pos_ff, pos_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_success_ff, rsp_success_in;
   logic                      rsp_found_ff, rsp_found_in;
   logic [POS_W-1:0]          rsp_position_ff, rsp_position_in;
   logic [CNT_W-1:0]          rsp_count_ff, rsp_count_in;
   logic                      rsp_full_ff, rsp_full_in;

   logic                      last_step;
   logic                      hit;
   logic                      is_append;
   logic                      has_room;
   logic                      do_append;
   logic [IW+POS_W-1:0]       pos_wide;
   logic [CW+CNT_W-1:0]       count_wide;

   // Status of the running walk.
   assign last_step  = CW'(step_ff) == (limit_ff - CW'(1));
   assign hit        = !found_ff && (head_value == key_ff);
   assign is_append  = (action_ff == ACT_PUSH) ||
                       ((action_ff == ACT_PUSH_UNIQUE) && !found_ff);
   assign has_room   = count_ff < CW'(CAPACITY);
   assign do_append  = is_append && has_room;
   assign pos_wide   = {{POS_W{1'b0}}, pos_ff};
   assign count_wide = {{CNT_W{1'b0}}, count_ff + CW'(do_append)};

   // Next state, chain operation and response.
   always_comb begin
      state_in        = state_ff;
      action_in       = action_ff;
      key_in          = key_ff;
      step_in         = step_ff;
      limit_in        = limit_ff;
      count_in        = count_ff;
      found_in        = found_ff;
      pos_in          = pos_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_chan.ready;
      rsp_success_in  = rsp_success_ff;
      rsp_found_in    = rsp_found_ff;
      rsp_position_in = rsp_position_ff;
      rsp_count_in    = rsp_count_ff;
      rsp_full_in     = rsp_full_ff;
      cell_ctrl.op    = OP_HOLD;
      cell_ctrl.wdata = key_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               action_in = action_type'(req_chan.action);
               key_in    = req_chan.value;
               step_in   = '0;
               limit_in  = count_ff;
               found_in  = 1'b0;
               pos_in    = '0;
               if (req_chan.action inside {[ACT_PUSH:ACT_REMOVE]}) begin
                  state_in = (count_ff == '0) ? ST_DONE : ST_SCAN;
               end else if (req_chan.action == ACT_SORT) begin
                  state_in = (count_ff < CW'(2)) ? ST_DONE : ST_SORT;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_SCAN: begin
            // One rotation step per cycle, or a drop on a removal hit; the head cell is compared.
            if (hit) begin
               found_in = 1'b1;
               pos_in   = step_ff;
            end
            if (hit && (action_ff == ACT_REMOVE)) begin
               cell_ctrl.op = OP_DROP;
               count_in     = count_ff - CW'(1);
            end else begin
               cell_ctrl.op = OP_ROTATE;
            end
            step_in = step_ff + IW'(1);
            if (last_step) begin
               state_in = ST_DONE;
            end
         end
         ST_SORT: begin
            // One odd-even transposition round per cycle.
            cell_ctrl.op = step_ff[0] ? OP_SWAP_ODD : OP_SWAP_EVEN;
            step_in      = step_ff + IW'(1);
            if (last_step) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               if (do_append) begin
                  cell_ctrl.op = OP_WRITE;
                  count_in     = count_ff + CW'(1);
               end
               rsp_valid_in    = 1'b1;
               rsp_success_in  = do_append || (action_ff == ACT_SORT) ||
                                 ((action_ff == ACT_REMOVE) && found_ff);
               rsp_found_in    = found_ff;
               rsp_position_in = pos_wide[POS_W-1:0];
               rsp_count_in    = count_wide[CNT_W-1:0];
               rsp_full_in     = is_append && !has_room;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         limit_ff     <= '0;
         count_ff     <= '0;
         found_ff     <= 1'b0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         limit_ff     <= limit_in;
         count_ff     <= count_in;
         found_ff     <= found_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      action_ff       <= action_in;
      key_ff          <= key_in;
      rsp_success_ff  <= rsp_success_in;
      rsp_found_ff    <= rsp_found_in;
      rsp_position_ff <= rsp_position_in;
      rsp_count_ff    <= rsp_count_in;
      rsp_full_ff     <= rsp_full_in;
   end

   assign req_chan.ready     = (state_ff == ST_IDLE);
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.success   = rsp_success_ff;
   assign rsp_chan.found     = rsp_found_ff;
   assign rsp_chan.position  = rsp_position_ff;
   assign rsp_chan.count_now = rsp_count_ff;
   assign rsp_chan.full_res  = rsp_full_ff;
   assign count              = count_ff;

endmodule

// ----- design/int_list_table_engine.sv -----
// ----------------------------------------------------------------------------
// int_list_table_engine: bounded list of signed values with search and sort
// A chain of CAPACITY cells holds the entries; a sequencer rotates the
// chain past the head for searches and removals and runs odd-even
// transposition rounds for the sort.
//
//   Channel    Direction  Word contents
//   req_chan   in         action, value
//   rsp_chan   out        success, found, position, count_now, full_res
//
// Push, push unique, find and remove make n rotation steps of the chain,
// with n the entries held, one step per cycle, between acceptance in the
// idle state and the finish state. Sort makes n transposition rounds
// between the same states; an empty list, a list of one entry for sort,
// or an unused action code goes from acceptance straight to finishing.
// Reset clears the count and the control; entries need no clearing.
// A finished word waits in the output register while the next request
// is taken; a stalled response holds the engine only in its finish cycle.
// ----------------------------------------------------------------------------
module int_list_table_engine import ilt_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   ilt_req_if.sink   req_chan,
   ilt_rsp_if.source rsp_chan
);

   localparam int IW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY+1);

   cell_ctrl_type             cell_ctrl;
   logic [CW-1:0]             count;
   logic signed [VALUE_W-1:0] cell_value [CAPACITY];

   // Sequencer.
   ilt_ctrl #(
      .CAPACITY (CAPACITY)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .rsp_chan   (rsp_chan),
      .head_value (cell_value[0]),
      .cell_ctrl  (cell_ctrl),
      .count      (count)
   );

   // Chain of entry cells, each linked to both neighbors.
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic signed [VALUE_W-1:0] left_value;
      logic signed [VALUE_W-1:0] right_value;

      if (g == 0) begin : g_first
         assign left_value = '0;
      end else begin : g_inner_left
         assign left_value = cell_value[g-1];
      end

      if (g == CAPACITY-1) begin : g_last
         assign right_value = '0;
      end else begin : g_inner_right
         assign right_value = cell_value[g+1];
      end

      ilt_cell #(
         .CAPACITY (CAPACITY)
      ) u_cell (
         .clock        (clock),
         .cell_index   (IW'(g)),
         .count        (count),
         .ctrl         (cell_ctrl),
         .head_value   (cell_value[0]),
         .left_value   (left_value),
         .right_value  (right_value),
         .stored_value (cell_value[g])
      );
   end

endmodule

// ----- design/ilt_checker.sv -----
// ----------------------------------------------------------------------------
// ilt_checker: port-level checks of the integer list engine
// Watches the request and response words at the top level's ports.
// ----------------------------------------------------------------------------
module ilt_checker import ilt_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic             rsp_success,
   input logic             rsp_found,
   input logic [POS_W-1:0] rsp_position,
   input logic [CNT_W-1:0] rsp_count_now,
   input logic             rsp_full_res
);

   // The engine works on one request at a time.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while a request was in progress");

   // A response word shows no position unless the value was found.
   a_position_needs_found: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> (rsp_position == '0))
      else $error("position reported without a match");

   // A refused append never reports success.
   a_full_not_success: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_full_res) |-> !rsp_success)
      else $error("full and success flagged together");

   // A stalled response word holds its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_success) && $stable(rsp_found) &&
          $stable(rsp_position) && $stable(rsp_count_now) && $stable(rsp_full_res)))
      else $error("stalled response word changed");

endmodule

bind int_list_table_engine ilt_checker u_ilt_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_success   (rsp_chan.success),
   .rsp_found     (rsp_chan.found),
   .rsp_position  (rsp_chan.position),
   .rsp_count_now (rsp_chan.count_now),
   .rsp_full_res  (rsp_chan.full_res)
);

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the integer list engine
// Request words drive push, push unique, find, remove, sort and unused action
// codes into the engine. A behavioral copy of the list predicts every response
// word as the request is accepted. A sink process compares the responses in
// order, field by field. The sender works in random bursts and the sink
// stalls on patterns of its own. One long sink hold-off fills the engine
// and stalls its input.
// ----------------------------------------------------------------------------
module tb_top;
   import ilt_pkg::*;

   localparam int LIST_DEPTH   = CAPACITY_DEFAULT;
   localparam int RANDOM_WORDS = 440;
   localparam int CYCLE_LIMIT  = 3_000_000;
   localparam int REPORT_CAP   = 60;

   localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
   localparam logic signed [VALUE_W-1:0] VALUE_ODD_BITS  = 32'sh5555_5555;
   localparam logic signed [VALUE_W-1:0] VALUE_EVEN_BITS = 32'shAAAA_AAAA;

   // Action codes the engine does not define; they must leave the list alone.
   localparam logic [ACTION_W-1:0] ACT_FIRST_UNUSED = 3'd5;
   localparam logic [ACTION_W-1:0] ACT_LAST_UNUSED  = 3'd7;

   typedef enum int {PHASE_GROW, PHASE_SHRINK, PHASE_MIXED} mix_phase_type;
   typedef enum int {SINK_FLOW, SINK_COIN, SINK_SLOW} sink_mode_type;

   typedef struct packed {
      logic             success;
      logic             found;
      logic [POS_W-1:0] position;
      logic [CNT_W-1:0] count_now;
      logic             full_res;
   } list_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ilt_req_if req_bus ();
   ilt_rsp_if rsp_bus ();

   int_list_table_engine #(.CAPACITY(LIST_DEPTH)) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // Behavioral copy of the list, updated as each request word is accepted.
   logic signed [VALUE_W-1:0] held_entries [LIST_DEPTH];
   int                        held_count = 0;
   list_result_type           expected_results [$];

   int unsigned cycle_count   = 0;
   int unsigned error_count   = 0;
   int unsigned words_checked = 0;
   int unsigned burst_left    = 0;
   int unsigned hold_orders   = 0;
   int unsigned hold_length   = 0;
   int unsigned action_tally [8];
   int unsigned full_refusals = 0;
   int unsigned peak_count    = 0;
   int unsigned largest_sort  = 0;

   always #6 clock = ~clock;

   // Apply one action to the list copy and return the response it must give.
   function automatic list_result_type predict_list_action(
      input logic [ACTION_W-1:0]       act,
      input logic signed [VALUE_W-1:0] val
   );
      list_result_type           res;
      int                        hit;
      int                        i;
      int                        j;
      logic signed [VALUE_W-1:0] held;
      res = '0;
      hit = -1;
      // Every action except sort and the unused codes searches first.
      if (act <= ACT_REMOVE) begin
         for (i = 0; i < held_count && hit < 0; i++) begin
            if (held_entries[i] == val) hit = i;
         end
         if (hit >= 0) begin
            res.found    = 1'b1;
            res.position = hit[POS_W-1:0];
         end
      end
      case (act)
         ACT_PUSH, ACT_PUSH_UNIQUE: begin
            if (act == ACT_PUSH || hit < 0) begin
               if (held_count < LIST_DEPTH) begin
                  held_entries[held_count] = val;
                  held_count++;
                  res.success = 1'b1;
               end else begin
                  res.full_res = 1'b1;
               end
            end
         end
         ACT_REMOVE: begin
            if (hit >= 0) begin
               for (i = hit; i + 1 < held_count; i++) held_entries[i] = held_entries[i + 1];
               held_count--;
               res.success = 1'b1;
            end
         end
         ACT_SORT: begin
            // Insertion sort, compared as signed values.
            for (i = 1; i < held_count; i++) begin
               held = held_entries[i];
               j = i;
               while (j > 0 && held_entries[j - 1] > held) begin
                  held_entries[j] = held_entries[j - 1];
                  j--;
               end
               held_entries[j] = held;
            end
            res.success = 1'b1;
         end
         default: begin
         end
      endcase
      res.count_now = held_count[CNT_W-1:0];
      return res;
   endfunction

   // Values come from a small pool, the list itself, the full range or the extremes.
   function automatic logic signed [VALUE_W-1:0] pick_value(input int unsigned present_pct);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (held_count > 0 && roll < present_pct) begin
         return held_entries[$urandom_range(0, held_count - 1)];
      end
      roll = $urandom_range(0, 9);
      if (roll < 5) return int'($urandom_range(0, 16)) - 8;
      if (roll < 8) return $urandom;
      case ($urandom_range(0, 3))
         0: return VALUE_MAX;
         1: return VALUE_MIN;
         2: return '0;
         default: return -1;
      endcase
   endfunction

   // Action mix leans toward growth or shrinkage depending on the phase.
   function automatic logic [ACTION_W-1:0] pick_action(input mix_phase_type phase);
      int unsigned roll;
      if ($urandom_range(0, 99) < 3) begin
         return ACTION_W'($urandom_range(ACT_FIRST_UNUSED, ACT_LAST_UNUSED));
      end
      roll = $urandom_range(0, 99);
      case (phase)
         PHASE_GROW: begin
            if (roll < 55) return ACT_PUSH;
            if (roll < 75) return ACT_PUSH_UNIQUE;
            if (roll < 88) return ACT_FIND;
            if (roll < 96) return ACT_REMOVE;
         end
         PHASE_SHRINK: begin
            if (roll < 10) return ACT_PUSH;
            if (roll < 20) return ACT_PUSH_UNIQUE;
            if (roll < 35) return ACT_FIND;
            if (roll < 94) return ACT_REMOVE;
         end
         default: begin
            if (roll < 25) return ACT_PUSH;
            if (roll < 45) return ACT_PUSH_UNIQUE;
            if (roll < 65) return ACT_FIND;
            if (roll < 92) return ACT_REMOVE;
         end
      endcase
      return ACT_SORT;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      error_count++;
      if (error_count <= REPORT_CAP) begin
         $display("mismatch at response word %0d, %s: got %0h, expected %0h",
                  words_checked, what, got, want);
      end
   endtask

   // Compare one accepted response word with the oldest prediction.
   task automatic check_result();
      list_result_type want;
      words_checked++;
      if (expected_results.size() == 0) begin
         report_mismatch("word with no request waiting", 32'(rsp_bus.count_now), '0);
         return;
      end
      want = expected_results.pop_front();
      if (rsp_bus.success !== want.success)
         report_mismatch("success", 32'(rsp_bus.success), 32'(want.success));
      if (rsp_bus.found !== want.found)
         report_mismatch("found", 32'(rsp_bus.found), 32'(want.found));
      if (rsp_bus.position !== want.position)
         report_mismatch("position", 32'(rsp_bus.position), 32'(want.position));
      if (rsp_bus.count_now !== want.count_now)
         report_mismatch("count_now", 32'(rsp_bus.count_now), 32'(want.count_now));
      if (rsp_bus.full_res !== want.full_res)
         report_mismatch("full_res", 32'(rsp_bus.full_res), 32'(want.full_res));
   endtask

   // Offer one request word, predict it once accepted, then maybe end the burst.
   task automatic send_word(input logic [ACTION_W-1:0] act,
                            input logic signed [VALUE_W-1:0] val);
      list_result_type want;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
                                                  : $urandom_range(1, 12);
      end
      req_bus.valid  <= 1'b1;
      req_bus.action <= act;
      req_bus.value  <= val;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      want = predict_list_action(act, val);
      expected_results.push_back(want);
      action_tally[act]++;
      if (want.full_res) full_refusals++;
      if (held_count > peak_count) peak_count = held_count;
      if (act == ACT_SORT && held_count > largest_sort) largest_sort = held_count;
      burst_left--;
      if (burst_left == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
   endtask

   // Stop offering and wait until every predicted response has arrived.
   task automatic wait_until_drained();
      if (req_bus.valid !== 1'b0) req_bus.valid <= 1'b0;
      burst_left = 0;
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   // Extremes, every action and the corner cases on a short list.
   task automatic test_directed_cases();
      send_word(ACT_FIND, '0);
      send_word(ACT_REMOVE, 7);
      send_word(ACT_SORT, VALUE_EVEN_BITS);
      send_word(ACT_PUSH_UNIQUE, VALUE_MAX);
      send_word(ACT_SORT, '0);
      send_word(ACT_PUSH, VALUE_MIN);
      send_word(ACT_PUSH, '0);
      send_word(ACT_PUSH, -1);
      send_word(ACT_PUSH, '0);
      send_word(ACT_PUSH_UNIQUE, -1);
      send_word(ACT_FIND, '0);
      send_word(ACT_FIND, VALUE_ODD_BITS);
      send_word(ACT_PUSH, VALUE_EVEN_BITS);
      send_word(ACT_PUSH, VALUE_ODD_BITS);
      send_word(ACT_SORT, VALUE_ODD_BITS);
      send_word(ACT_FIND, VALUE_MIN);
      send_word(ACT_FIND, VALUE_MAX);
      send_word(ACT_REMOVE, '0);
      send_word(ACT_REMOVE, VALUE_MIN);
      send_word(ACT_REMOVE, VALUE_MAX);
      send_word(ACT_FIRST_UNUSED, VALUE_MAX);
      send_word(ACT_FIRST_UNUSED + 3'd1, '0);
      send_word(ACT_LAST_UNUSED, -1);
      send_word(ACT_REMOVE, 12345);
      send_word(ACT_PUSH_UNIQUE, 1);
   endtask

   // Fill the list to capacity, probe the full cases, then drain most of it.
   task automatic test_full_list();
      int unsigned target;
      while (held_count < LIST_DEPTH) begin
         send_word(($urandom_range(0, 3) == 0) ? ACT_PUSH_UNIQUE : ACT_PUSH, pick_value(10));
      end
      send_word(ACT_PUSH, pick_value(0));
      send_word(ACT_PUSH_UNIQUE, held_entries[LIST_DEPTH - 1]);
      send_word(ACT_PUSH_UNIQUE, $urandom);
      send_word(ACT_FIND, held_entries[LIST_DEPTH - 1]);
      send_word(ACT_SORT, $urandom);
      send_word(ACT_FIND, held_entries[0]);
      send_word(ACT_REMOVE, held_entries[LIST_DEPTH - 1]);
      send_word(ACT_PUSH, VALUE_MAX);
      send_word(ACT_PUSH, VALUE_MIN);
      target = $urandom_range(16, 48);
      while (held_count > target) begin
         send_word(($urandom_range(0, 7) == 0) ? ACT_FIND : ACT_REMOVE, pick_value(90));
      end
      wait_until_drained();
   endtask

   // Hold the sink off for a long stretch while the sender keeps offering.
   task automatic test_output_stall();
      int unsigned k;
      wait_until_drained();
      hold_length = 600;
      hold_orders++;
      @(posedge clock);
      burst_left = 20;
      for (k = 0; k < 16; k++) send_word(pick_action(PHASE_MIXED), pick_value(50));
      wait_until_drained();
      for (k = 0; k < 4; k++) send_word(ACT_FIND, pick_value(50));
      wait_until_drained();
   endtask

   // Long random mix in phases that grow, shrink or churn the list.
   task automatic test_random_mix();
      mix_phase_type            phase;
      int unsigned              phase_left;
      int unsigned              n;
      int unsigned              roll;
      logic [ACTION_W-1:0]      act;
      phase      = PHASE_MIXED;
      phase_left = 0;
      for (n = 0; n < RANDOM_WORDS; n++) begin
         if (phase_left == 0) begin
            roll = $urandom_range(0, 99);
            phase = (roll < 45) ? PHASE_GROW : (roll < 75) ? PHASE_SHRINK : PHASE_MIXED;
            phase_left = $urandom_range(40, 160);
         end
         phase_left--;
         act = pick_action(phase);
         send_word(act, pick_value((act == ACT_REMOVE) ? 75 : (act == ACT_FIND) ? 50 : 20));
         if ($urandom_range(0, 199) == 0) wait_until_drained();
      end
      wait_until_drained();
   endtask

   // Response sink: check each accepted word, then choose the next ready.
   initial begin : result_sink
      sink_mode_type mode;
      int unsigned   mode_left;
      int unsigned   hold_left;
      int unsigned   hold_served;
      mode        = SINK_FLOW;
      mode_left   = 0;
      hold_left   = 0;
      hold_served = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) check_result();
         if (hold_served != hold_orders) begin
            hold_served = hold_orders;
            hold_left   = hold_length;
         end
         if (mode_left == 0) begin
            mode      = sink_mode_type'($urandom_range(0, 2));
            mode_left = $urandom_range(16, 160);
         end else begin
            mode_left--;
         end
         if (reset || hold_left != 0) begin
            rsp_bus.ready <= 1'b0;
            if (hold_left != 0) hold_left--;
         end else begin
            case (mode)
               SINK_FLOW: rsp_bus.ready <= 1'b1;
               SINK_COIN: rsp_bus.ready <= ($urandom_range(0, 1) == 1);
               default:   rsp_bus.ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // Watchdog on the whole run.
   initial begin : run_watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("run timed out after %0d cycles with %0d responses outstanding",
               cycle_count, expected_results.size());
      $display("tb_top: FAIL");
      $finish;
   end

   // Test sequence.
   initial begin : test_sequence
      req_bus.valid  <= 1'b0;
      req_bus.action <= ACT_PUSH;
      req_bus.value  <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      wait_until_drained();
      test_full_list();
      test_output_stall();
      test_random_mix();
      wait_until_drained();
      repeat (LIST_DEPTH + 8) @(posedge clock);
      $display("Run covered %0d words: %0d push, %0d push-unique, %0d find, %0d remove,",
               words_checked, action_tally[ACT_PUSH], action_tally[ACT_PUSH_UNIQUE],
               action_tally[ACT_FIND], action_tally[ACT_REMOVE]);
      $display("%0d sort, %0d unused; list peaked at %0d of %0d entries, %0d full refusals,",
               action_tally[ACT_SORT],
               action_tally[ACT_FIRST_UNUSED] + action_tally[ACT_FIRST_UNUSED + 3'd1] +
               action_tally[ACT_LAST_UNUSED],
               peak_count, LIST_DEPTH, full_refusals);
      $display("largest sort %0d entries, %0d mismatches.", largest_sort, error_count);
      if (error_count == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule
